@@ sv/qcc_pkg.sv @@
// Shared constants and types for the quad/circle collision pipeline.
// No dependencies; every other file refers to this package by scoped names.
package qcc_pkg;

    // Default coordinate width and fixed radius width
    localparam int COORD_BITS_DEF = 16;
    localparam int RADIUS_BITS    = 15;

    // Result field widths and packed result width in bytes
    localparam int KIND_BITS  = 2;
    localparam int OUT_BYTES  = 1;

    // Result codes: first test that hit
    localparam logic [KIND_BITS-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_CORNER = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_EDGE   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_INSIDE = 2'd3;

    // Edge walk: 0-1, 1-3, 3-2, 2-0
    localparam logic [1:0] EDGE_FROM [4] = '{2'd0, 2'd1, 2'd3, 2'd2};
    localparam logic [1:0] EDGE_TO   [4] = '{2'd1, 2'd3, 2'd2, 2'd0};

    // Test flags that travel beside the wide edge terms
    typedef struct packed {
        logic       corner_hit;   // a corner lies strictly inside the circle
        logic       in_quad;      // centre passes both inside checks
        logic [3:0] proj_ok;      // centre projects strictly inside each edge
    } t_tests;

endpackage

@@ sv/qcc_front.sv @@
// Front stages of the collision pipeline: differences, products, sums.
// Produces the corner, projection and inside verdicts, the signed edge cross terms,
// the squared edge lengths and r^2. Depends on qcc_pkg.
module qcc_front #(
    parameter int COORD_BITS = qcc_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [COORD_BITS-1:0]      i_cx [4],
    input  logic signed [COORD_BITS-1:0]      i_cy [4],
    input  logic signed [COORD_BITS-1:0]      i_mx,
    input  logic signed [COORD_BITS-1:0]      i_my,
    input  logic [qcc_pkg::RADIUS_BITS-1:0]   i_rad,
    output logic                              o_valid,
    output qcc_pkg::t_tests                   o_tests,
    output logic signed [2*COORD_BITS+1:0]    o_cross [4],
    output logic [2*COORD_BITS+1:0]           o_len2 [4],
    output logic [2*qcc_pkg::RADIUS_BITS-1:0] o_r2
);

    localparam int D   = COORD_BITS + 1;
    localparam int P   = 2 * COORD_BITS + 2;
    localparam int R2W = 2 * qcc_pkg::RADIUS_BITS;
    localparam int CW  = (P > R2W) ? P : R2W;

    // Stage 1: centre-to-corner and edge vectors
    logic                             r_v1;
    logic signed [D-1:0]              r_dx [4];
    logic signed [D-1:0]              r_dy [4];
    logic signed [D-1:0]              r_ex [4];
    logic signed [D-1:0]              r_ey [4];
    logic [qcc_pkg::RADIUS_BITS-1:0]  r_rad1;

    // Stage 2: products
    logic                             r_v2;
    logic signed [P-1:0]              r_sqx [4];
    logic signed [P-1:0]              r_sqy [4];
    logic signed [P-1:0]              r_pc1 [4];
    logic signed [P-1:0]              r_pc2 [4];
    logic signed [P-1:0]              r_pl1 [4];
    logic signed [P-1:0]              r_pl2 [4];
    logic signed [P-1:0]              r_pa1 [4];
    logic signed [P-1:0]              r_pa2 [4];
    logic signed [P-1:0]              r_pb1 [4];
    logic signed [P-1:0]              r_pb2 [4];
    logic [R2W-1:0]                   r_r2_2;

    // Stage 3: sums and verdicts
    logic                             r_v3;
    qcc_pkg::t_tests                  r_tests;
    logic signed [P-1:0]              r_cross [4];
    logic [P-1:0]                     r_len2 [4];
    logic [R2W-1:0]                   r_r2_3;

    logic signed [P-1:0]              n_cross [4];
    logic signed [P-1:0]              w_d1 [4];
    logic signed [P-1:0]              w_d2 [4];
    logic [P-1:0]                     w_dist [4];
    qcc_pkg::t_tests                  n_tests;

    // Advance valid bits on every enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage 1: differences, one bit wider than the coordinates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_dx[i] <= {i_mx[COORD_BITS-1], i_mx} - {i_cx[i][COORD_BITS-1], i_cx[i]};
                r_dy[i] <= {i_my[COORD_BITS-1], i_my} - {i_cy[i][COORD_BITS-1], i_cy[i]};
            end
            for (int k = 0; k < 4; k++) begin
                r_ex[k] <= {i_cx[qcc_pkg::EDGE_TO[k]][COORD_BITS-1], i_cx[qcc_pkg::EDGE_TO[k]]}
                         - {i_cx[qcc_pkg::EDGE_FROM[k]][COORD_BITS-1],
                            i_cx[qcc_pkg::EDGE_FROM[k]]};
                r_ey[k] <= {i_cy[qcc_pkg::EDGE_TO[k]][COORD_BITS-1], i_cy[qcc_pkg::EDGE_TO[k]]}
                         - {i_cy[qcc_pkg::EDGE_FROM[k]][COORD_BITS-1],
                            i_cy[qcc_pkg::EDGE_FROM[k]]};
            end
            r_rad1 <= i_rad;
        end
    end

    // Stage 2: all products, one multiplier each
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_sqx[i] <= r_dx[i] * r_dx[i];
                r_sqy[i] <= r_dy[i] * r_dy[i];
            end
            for (int k = 0; k < 4; k++) begin
                r_pc1[k] <= r_dx[qcc_pkg::EDGE_FROM[k]] * r_ey[k];
                r_pc2[k] <= r_dy[qcc_pkg::EDGE_FROM[k]] * r_ex[k];
                r_pl1[k] <= r_ex[k] * r_ex[k];
                r_pl2[k] <= r_ey[k] * r_ey[k];
                r_pa1[k] <= r_dx[qcc_pkg::EDGE_FROM[k]] * r_ex[k];
                r_pa2[k] <= r_dy[qcc_pkg::EDGE_FROM[k]] * r_ey[k];
                r_pb1[k] <= r_dx[qcc_pkg::EDGE_TO[k]] * r_ex[k];
                r_pb2[k] <= r_dy[qcc_pkg::EDGE_TO[k]] * r_ey[k];
            end
            r_r2_2 <= r_rad1 * r_rad1;
        end
    end

    // Stage 3: sums, corner test, projection signs and inside test
    always_comb begin
        n_tests = '0;
        for (int i = 0; i < 4; i++) begin
            w_dist[i] = $unsigned(r_sqx[i] + r_sqy[i]);
            if (CW'(w_dist[i]) < CW'(r_r2_2)) begin
                n_tests.corner_hit = 1'b1;
            end
        end
        for (int k = 0; k < 4; k++) begin
            n_cross[k] = r_pc1[k] - r_pc2[k];
            w_d1[k]    = r_pa1[k] + r_pa2[k];
            w_d2[k]    = r_pb1[k] + r_pb2[k];
            // signs strictly opposite: one negative, the other positive
            n_tests.proj_ok[k] = (w_d1[k][P-1] && !w_d2[k][P-1] && (w_d2[k] != '0))
                              || (w_d2[k][P-1] && !w_d1[k][P-1] && (w_d1[k] != '0));
        end
        // edge 0 runs from corner 0 to 1, edge 2 from corner 3 to 2;
        // the inside cross term is the negated edge cross term
        n_tests.in_quad = !w_d1[0][P-1] && (n_cross[0][P-1] || (n_cross[0] == '0))
                       && !w_d1[2][P-1] && (n_cross[2][P-1] || (n_cross[2] == '0));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tests <= n_tests;
            for (int k = 0; k < 4; k++) begin
                r_cross[k] <= n_cross[k];
                r_len2[k]  <= $unsigned(r_pl1[k] + r_pl2[k]);
            end
            r_r2_3 <= r_r2_2;
        end
    end

    assign o_valid = r_v3;
    assign o_tests = r_tests;
    assign o_cross = r_cross;
    assign o_len2  = r_len2;
    assign o_r2    = r_r2_3;

endmodule

@@ sv/qcc_edge.sv @@
// Edge distance stages: magnitude of the cross term, split partial products
// for cross^2 and r^2*len^2, and their sums. Depends on qcc_pkg.
module qcc_edge #(
    parameter int COORD_BITS = qcc_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  qcc_pkg::t_tests                   i_tests,
    input  logic signed [2*COORD_BITS+1:0]    i_cross [4],
    input  logic [2*COORD_BITS+1:0]           i_len2 [4],
    input  logic [2*qcc_pkg::RADIUS_BITS-1:0] i_r2,
    output logic                              o_valid,
    output qcc_pkg::t_tests                   o_tests,
    output logic [4*COORD_BITS+4+2*qcc_pkg::RADIUS_BITS-1:0] o_lhs [4],
    output logic [4*COORD_BITS+4+2*qcc_pkg::RADIUS_BITS-1:0] o_rhs [4]
);

    localparam int W   = 2 * COORD_BITS + 2;
    localparam int H   = COORD_BITS + 1;
    localparam int R2W = 2 * qcc_pkg::RADIUS_BITS;
    localparam int LW  = 2 * W + R2W;

    // Stage 4: magnitudes
    logic                 r_v4;
    qcc_pkg::t_tests      r_tests4;
    logic [W-1:0]         r_mag [4];
    logic [W-1:0]         r_len4 [4];
    logic [R2W-1:0]       r_r2_4;

    // Stage 5: partial products on half-width slices
    logic                 r_v5;
    qcc_pkg::t_tests      r_tests5;
    logic [2*H-1:0]       r_hh [4];
    logic [2*H-1:0]       r_hl [4];
    logic [2*H-1:0]       r_ll [4];
    logic [R2W+H-1:0]     r_rh [4];
    logic [R2W+H-1:0]     r_rl [4];

    // Stage 6: recombined sides of the distance compare
    logic                 r_v6;
    qcc_pkg::t_tests      r_tests6;
    logic [LW-1:0]        r_lhs [4];
    logic [LW-1:0]        r_rhs [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    // Stage 4: take the absolute cross term
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tests4 <= i_tests;
            for (int k = 0; k < 4; k++) begin
                r_mag[k]  <= i_cross[k][W-1] ? $unsigned(-i_cross[k]) : $unsigned(i_cross[k]);
                r_len4[k] <= i_len2[k];
            end
            r_r2_4 <= i_r2;
        end
    end

    // Stage 5: square and scale through half-width multipliers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tests5 <= r_tests4;
            for (int k = 0; k < 4; k++) begin
                r_hh[k] <= r_mag[k][W-1:H] * r_mag[k][W-1:H];
                r_hl[k] <= r_mag[k][W-1:H] * r_mag[k][H-1:0];
                r_ll[k] <= r_mag[k][H-1:0] * r_mag[k][H-1:0];
                r_rh[k] <= r_r2_4 * r_len4[k][W-1:H];
                r_rl[k] <= r_r2_4 * r_len4[k][H-1:0];
            end
        end
    end

    // Stage 6: shift and add the partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tests6 <= r_tests5;
            for (int k = 0; k < 4; k++) begin
                r_lhs[k] <= (LW'(r_hh[k]) << (2 * H)) + (LW'(r_hl[k]) << (H + 1))
                          + LW'(r_ll[k]);
                r_rhs[k] <= (LW'(r_rh[k]) << H) + LW'(r_rl[k]);
            end
        end
    end

    assign o_valid = r_v6;
    assign o_tests = r_tests6;
    assign o_lhs   = r_lhs;
    assign o_rhs   = r_rhs;

endmodule

@@ sv/quad_circle_collision_top.sv @@
// Quad/circle collision test: corner, edge and inside checks in a pipeline.
// Pipeline: seven register stages, the first loaded by the input transfer and the last
// holding the result on the master side.
// Throughput: one item per cycle; the whole pipeline holds while the output waits.
// Reset (synchronous, active low) clears the valid bits; data registers are not reset.
// Depends on qcc_pkg, qcc_front and qcc_edge.
module quad_circle_collision_top #(
    parameter int COORD_BITS = qcc_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // slave side
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // from bit 0: corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
    // corner3_x, corner3_y, circle_x, circle_y, circle_radius, zero fill
    input  logic [((10*COORD_BITS+qcc_pkg::RADIUS_BITS+7)/8)*8-1:0] i_s_tdata,
    // master side
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // from bit 0: hit, hit_kind, zero fill
    output logic [8*qcc_pkg::OUT_BYTES-1:0] o_m_tdata
);

    localparam int W   = 2 * COORD_BITS + 2;
    localparam int R2W = 2 * qcc_pkg::RADIUS_BITS;
    localparam int LW  = 2 * W + R2W;
    localparam int OW  = 8 * qcc_pkg::OUT_BYTES;

    logic                               w_en;
    logic signed [COORD_BITS-1:0]       w_cx [4];
    logic signed [COORD_BITS-1:0]       w_cy [4];
    logic signed [COORD_BITS-1:0]       w_mx;
    logic signed [COORD_BITS-1:0]       w_my;
    logic [qcc_pkg::RADIUS_BITS-1:0]    w_rad;

    logic                               w_fv;
    qcc_pkg::t_tests                    w_ftests;
    logic signed [W-1:0]                w_cross [4];
    logic [W-1:0]                       w_len2 [4];
    logic [R2W-1:0]                     w_r2;

    logic                               w_ev;
    qcc_pkg::t_tests                    w_etests;
    logic [LW-1:0]                      w_lhs [4];
    logic [LW-1:0]                      w_rhs [4];

    logic                               r_m_valid;
    logic                               r_hit;
    logic [qcc_pkg::KIND_BITS-1:0]      r_kind;
    logic [qcc_pkg::KIND_BITS-1:0]      n_kind;
    logic                               w_edge_hit;

    // Advance the pipeline unless a finished result is still waiting
    assign w_en       = !r_m_valid || i_m_tready;
    assign o_s_tready = w_en;

    // Unpack the input transfer
    for (genvar i = 0; i < 4; i++) begin : g_corner
        assign w_cx[i] = i_s_tdata[2*i*COORD_BITS +: COORD_BITS];
        assign w_cy[i] = i_s_tdata[(2*i+1)*COORD_BITS +: COORD_BITS];
    end
    assign w_mx  = i_s_tdata[8*COORD_BITS +: COORD_BITS];
    assign w_my  = i_s_tdata[9*COORD_BITS +: COORD_BITS];
    assign w_rad = i_s_tdata[10*COORD_BITS +: qcc_pkg::RADIUS_BITS];

    qcc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_cx    (w_cx),
        .i_cy    (w_cy),
        .i_mx    (w_mx),
        .i_my    (w_my),
        .i_rad   (w_rad),
        .o_valid (w_fv),
        .o_tests (w_ftests),
        .o_cross (w_cross),
        .o_len2  (w_len2),
        .o_r2    (w_r2)
    );

    qcc_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_tests (w_ftests),
        .i_cross (w_cross),
        .i_len2  (w_len2),
        .i_r2    (w_r2),
        .o_valid (w_ev),
        .o_tests (w_etests),
        .o_lhs   (w_lhs),
        .o_rhs   (w_rhs)
    );

    // Final compare and priority: corner, then edge, then inside
    always_comb begin
        w_edge_hit = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if ((w_lhs[k] < w_rhs[k]) && w_etests.proj_ok[k]) begin
                w_edge_hit = 1'b1;
            end
        end
        if (w_etests.corner_hit) begin
            n_kind = qcc_pkg::KIND_CORNER;
        end else if (w_edge_hit) begin
            n_kind = qcc_pkg::KIND_EDGE;
        end else if (w_etests.in_quad) begin
            n_kind = qcc_pkg::KIND_INSIDE;
        end else begin
            n_kind = qcc_pkg::KIND_NONE;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= w_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kind <= n_kind;
            r_hit  <= (n_kind != qcc_pkg::KIND_NONE);
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{(OW - 1 - qcc_pkg::KIND_BITS){1'b0}}, r_kind, r_hit};

endmodule

@@ tb/quad_circle_collision_checker.sv @@
// Scoreboard for the quad/circle collision block: watches both stream channels,
// predicts the hit result of every accepted quad and checks results in order.
// Depends on qcc_pkg for the hit-kind codes and the edge walk order.
module quad_circle_collision_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    // from bit 0: corner0_x .. corner3_y, circle_x, circle_y, circle_radius, zero fill
    input  logic [175:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // from bit 0: hit, hit_kind, zero fill
    input  logic [7:0]   i_m_tdata,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_checked,
    output int           o_corner_hits,
    output int           o_edge_hits,
    output int           o_inside_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 40;

    // Query layout on the slave side, last field in the top bits
    typedef struct packed {
        logic               fill;
        logic        [14:0] circle_radius;
        logic signed [15:0] circle_y;
        logic signed [15:0] circle_x;
        logic signed [15:0] corner3_y;
        logic signed [15:0] corner3_x;
        logic signed [15:0] corner2_y;
        logic signed [15:0] corner2_x;
        logic signed [15:0] corner1_y;
        logic signed [15:0] corner1_x;
        logic signed [15:0] corner0_y;
        logic signed [15:0] corner0_x;
    } t_quad_circle;

    // Result layout on the master side
    typedef struct packed {
        logic [1:0] hit_kind;
        logic       hit;
    } t_collision;

    t_collision expected_hits_q[$];

    // Exact collision verdict: corner test, then edge test, then the inside test
    function automatic t_collision predict_collision(t_quad_circle q);
        longint     px[4];
        longint     py[4];
        longint     mx, my, rr, r2;
        longint     dx, dy, ex, ey, wx, wy, cr, len2, d1, d2, dt;
        logic [127:0] cr_mag, r2_w, len_w, lhs, rhs;
        logic [1:0] kind;
        logic       centre_in;
        int         p, n;
        t_collision res;

        px[0] = q.corner0_x;  py[0] = q.corner0_y;
        px[1] = q.corner1_x;  py[1] = q.corner1_y;
        px[2] = q.corner2_x;  py[2] = q.corner2_y;
        px[3] = q.corner3_x;  py[3] = q.corner3_y;
        mx = q.circle_x;
        my = q.circle_y;
        rr = q.circle_radius;
        r2 = rr * rr;
        kind = qcc_pkg::KIND_NONE;

        // corner strictly inside the circle
        for (int i = 0; i < 4; i++) begin
            dx = mx - px[i];
            dy = my - py[i];
            if (kind == qcc_pkg::KIND_NONE && dx * dx + dy * dy < r2) begin
                kind = qcc_pkg::KIND_CORNER;
            end
        end

        // edge closer than r with the centre projecting strictly between its ends
        for (int i = 0; i < 4; i++) begin
            p = qcc_pkg::EDGE_FROM[i];
            n = qcc_pkg::EDGE_TO[i];
            ex = px[n] - px[p];
            ey = py[n] - py[p];
            wx = mx - px[p];
            wy = my - py[p];
            cr = wx * ey - wy * ex;
            len2 = ex * ex + ey * ey;
            cr_mag = (cr < 0) ? -cr : cr;
            r2_w = r2;
            len_w = len2;
            lhs = cr_mag * cr_mag;
            rhs = r2_w * len_w;
            if (kind == qcc_pkg::KIND_NONE && lhs < rhs) begin
                d1 = wx * ex + wy * ey;
                d2 = (mx - px[n]) * ex + (my - py[n]) * ey;
                if ((d1 > 0 && d2 < 0) || (d1 < 0 && d2 > 0)) begin
                    kind = qcc_pkg::KIND_EDGE;
                end
            end
        end

        // centre inside, judged from corner 0 toward 1 and from corner 3 toward 2
        centre_in = 1'b1;
        for (int i = 0; i < 2; i++) begin
            p = i * 3;
            n = 1 + i;
            ex = px[n] - px[p];
            ey = py[n] - py[p];
            wx = mx - px[p];
            wy = my - py[p];
            dt = ex * wx + ey * wy;
            cr = ex * wy - ey * wx;
            if (dt < 0 || cr < 0) begin
                centre_in = 1'b0;
            end
        end
        if (kind == qcc_pkg::KIND_NONE && centre_in) begin
            kind = qcc_pkg::KIND_INSIDE;
        end

        res.hit_kind = kind;
        res.hit = (kind != qcc_pkg::KIND_NONE);
        return res;
    endfunction

    function automatic void note_failure();
        o_fail_count++;
        if (o_fail_count == MAX_REPORTS) begin
            $display("Further mismatches are counted without a report");
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
        o_corner_hits = 0;
        o_edge_hits = 0;
        o_inside_hits = 0;
    end

    // Queue a prediction per query transfer; check each result transfer in order
    always @(posedge i_clk) begin
        t_collision got;
        t_collision want;
        if (i_rst_n && i_s_tvalid && i_s_tready) begin
            expected_hits_q.push_back(predict_collision(t_quad_circle'(i_s_tdata)));
        end
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            got = t_collision'(i_m_tdata[2:0]);
            if (expected_hits_q.size() == 0) begin
                if (o_fail_count < MAX_REPORTS) begin
                    $error("result transfer with no query outstanding: hit %0d, hit_kind %0d",
                           got.hit, got.hit_kind);
                end
                note_failure();
            end else begin
                want = expected_hits_q.pop_front();
                o_checked++;
                if (got.hit !== want.hit) begin
                    if (o_fail_count < MAX_REPORTS) begin
                        $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                    end
                    note_failure();
                end
                if (got.hit_kind !== want.hit_kind) begin
                    if (o_fail_count < MAX_REPORTS) begin
                        $error("hit_kind: expected %0d, actual %0d", want.hit_kind,
                               got.hit_kind);
                    end
                    note_failure();
                end
                case (want.hit_kind)
                    qcc_pkg::KIND_CORNER: o_corner_hits++;
                    qcc_pkg::KIND_EDGE:   o_edge_hits++;
                    qcc_pkg::KIND_INSIDE: o_inside_hits++;
                    default: ;
                endcase
            end
        end
        o_pending = expected_hits_q.size();
    end

endmodule

@@ tb/quad_circle_collision_top_tb.sv @@
// Top of the quad/circle collision regression: drives quads and circles into the
// block with random idle bursts on both sides and reports the verdict.
// Depends on qcc_pkg, quad_circle_collision_top and quad_circle_collision_checker.
module quad_circle_collision_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 650;
    localparam int QUIET_ITEMS  = 100;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;

    // Query layout on the slave side, last field in the top bits
    typedef struct packed {
        logic               fill;
        logic        [14:0] circle_radius;
        logic signed [15:0] circle_y;
        logic signed [15:0] circle_x;
        logic signed [15:0] corner3_y;
        logic signed [15:0] corner3_x;
        logic signed [15:0] corner2_y;
        logic signed [15:0] corner2_x;
        logic signed [15:0] corner1_y;
        logic signed [15:0] corner1_x;
        logic signed [15:0] corner0_y;
        logic signed [15:0] corner0_x;
    } t_quad_circle;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [175:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;

    logic         query_taken = 1'b0;
    logic         quiet = 1'b0;
    int           src_gap_pct = 0;
    int           sink_stall_pct = 0;
    int           stall_left = 0;
    int           sink_phase = 0;
    int           cycles = 0;
    int           quads_sent = 0;

    int           fail_count;
    int           pending;
    int           checked;
    int           corner_hits;
    int           edge_hits;
    int           inside_hits;

    quad_circle_collision_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    quad_circle_collision_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_corner_hits (corner_hits),
        .o_edge_hits   (edge_hits),
        .o_inside_hits (inside_hits)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Note each query transfer so the driver can see it at the falling edge
    always @(posedge clk) begin
        query_taken <= s_tvalid && s_tready;
    end

    // Give up on a hung run
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: stall in bursts of random length at a stall rate redrawn periodically
    always @(negedge clk) begin
        sink_phase <= sink_phase + 1;
        if (sink_phase % 64 == 0) begin
            sink_stall_pct <= $urandom_range(2) * 15;
        end
        if (quiet || !rst_n) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < sink_stall_pct) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(7, 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Present one query, with an optional idle burst first, and hold it until taken
    task automatic send_query(input t_quad_circle q);
        int gap;
        if (!quiet && $urandom_range(99) < src_gap_pct) begin
            gap = $urandom_range(8, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= q;
        @(negedge clk);
        while (!query_taken) @(negedge clk);
        quads_sent++;
    endtask

    task automatic send_quad(input int x0, input int y0, input int x1, input int y1,
                             input int x2, input int y2, input int x3, input int y3,
                             input int cx, input int cy, input int r);
        t_quad_circle q;
        q.fill          = 1'b0;
        q.corner0_x     = 16'(x0);
        q.corner0_y     = 16'(y0);
        q.corner1_x     = 16'(x1);
        q.corner1_y     = 16'(y1);
        q.corner2_x     = 16'(x2);
        q.corner2_y     = 16'(y2);
        q.corner3_x     = 16'(x3);
        q.corner3_y     = 16'(y3);
        q.circle_x      = 16'(cx);
        q.circle_y      = 16'(cy);
        q.circle_radius = 15'(r);
        send_query(q);
    endtask

    // Fully random fields over their whole range
    task automatic send_noise();
        t_quad_circle q;
        q = 176'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        q.fill = 1'b0;
        send_query(q);
    endtask

    // Rotated rectangle with integer side vectors and a circle somewhere around it;
    // a broken one gets a corner moved or an edge collapsed
    task automatic send_rect(input bit broken);
        int ux, uy, vx, vy, la, lb, ox, oy, s, t, cx, cy, sz, r;
        int x[4];
        int y[4];
        int k;
        ux = int'($urandom_range(40)) - 20;
        uy = int'($urandom_range(40)) - 20;
        if (ux == 0 && uy == 0) begin
            ux = 1;
        end
        if ($urandom_range(1)) begin
            vx = -uy;  vy = ux;
        end else begin
            vx = uy;   vy = -ux;
        end
        if ($urandom_range(19) == 0) begin
            la = $urandom_range(1500, 1);
            lb = $urandom_range(1500, 1);
        end else begin
            la = $urandom_range(30, 1);
            lb = $urandom_range(30, 1);
        end
        ox = int'($urandom_range(65535)) - 32768;
        oy = int'($urandom_range(65535)) - 32768;
        x[0] = ox;                     y[0] = oy;
        x[1] = ox + la * ux;           y[1] = oy + la * uy;
        x[2] = ox + lb * vx;           y[2] = oy + lb * vy;
        x[3] = ox + la * ux + lb * vx; y[3] = oy + la * uy + lb * vy;
        if (broken) begin
            k = $urandom_range(3);
            if ($urandom_range(1)) begin
                x[k] = x[qcc_pkg::EDGE_TO[k]];
                y[k] = y[qcc_pkg::EDGE_TO[k]];
            end else begin
                x[k] += int'($urandom_range(200)) - 100;
                y[k] += int'($urandom_range(200)) - 100;
            end
        end
        // centre in percent of the side vectors, reaching a bit past the sides
        s = int'($urandom_range(160)) - 30;
        t = int'($urandom_range(160)) - 30;
        cx = ox + (s * la * ux + t * lb * vx) / 100;
        cy = oy + (s * la * uy + t * lb * vy) / 100;
        sz = (la + lb) * ((ux < 0 ? -ux : ux) + (uy < 0 ? -uy : uy)) / 2 + 1;
        if (sz > 32767) begin
            sz = 32767;
        end
        r = $urandom_range(2) == 0 ? $urandom_range(4) : $urandom_range(sz);
        send_quad(x[0], y[0], x[1], y[1], x[2], y[2], x[3], y[3], cx, cy, r);
    endtask

    initial begin
        int pick;
        // hold reset low, then release it at a falling edge
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: degenerate and touching cases, field extremes, bit patterns
        src_gap_pct = 30;
        send_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        send_quad(0, 0, 100, 0, 0, 100, 100, 100, 50, 50, 1);
        send_quad(0, 0, 100, 0, 0, 100, 100, 100, 50, -5, 10);
        send_quad(0, 0, 100, 0, 0, 100, 100, 100, -3, -4, 5);
        send_quad(0, 0, 100, 0, 0, 100, 100, 100, -3, -4, 6);
        send_quad(0, 0, 100, 0, 0, 100, 100, 100, 50, -10, 10);
        send_quad(0, 0, 100, 0, 0, 100, 100, 100, 105, 40, 8);
        send_quad(0, 0, 100, 0, 0, 100, 100, 100, 30, 103, 4);
        send_quad(0, 0, 100, 0, 0, 100, 100, 100, 50, 500, 3);
        send_quad(0, 0, 100, 0, 0, 100, 100, 100, 100, 100, 0);
        send_quad(0, 0, 0, 100, 100, 0, 100, 100, 50, 50, 1);
        send_quad(10, 10, 10, 10, 10, 10, 10, 10, 12, 10, 1);
        send_quad(0, 0, 0, 0, 0, 100, 100, 100, 50, 20, 30);
        send_quad(0, 0, 200, 30, -20, 150, 300, 400, 100, 100, 5);
        send_quad(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767, 0, 0, 32767);
        send_quad(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                  -32768, -32768, 32767);
        send_quad(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                  32767, 32767, 32767);
        send_quad(21845, -21846, 21845, -21846, 21845, -21846, 21845, -21846,
                  21845, -21846, 10922);
        send_quad(-21846, 21845, -21846, 21845, -21846, 21845, -21846, 21845,
                  -21846, 21845, 21845);
        send_quad(-32768, -32768, -32000, -32768, -32768, -32000, -32000, -32000,
                  32767, 32767, 32767);
        send_quad(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768,
                  0, 0, 16384);

        // Random: mostly rectangles, some broken quads, some raw noise
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) begin
                src_gap_pct = $urandom_range(2) * 20;
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_rect(1'b0);
            end else if (pick < 85) begin
                send_rect(1'b1);
            end else begin
                send_noise();
            end
        end
        s_tvalid <= 1'b0;

        // Drain the pipeline, then keep watching for stray results
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d quads, checked %0d results in %0d cycles", quads_sent, checked,
                 cycles);
        $display("Hits by first test: corner %0d, edge %0d, inside %0d, none %0d",
                 corner_hits, edge_hits, inside_hits,
                 checked - corner_hits - edge_hits - inside_hits);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
